[rtl/octal_escape_header_extractor_core_assert.svh]
// Assertion shorthands; clock clk_i and reset rst_ni are implied.
`ifndef OCTAL_ESCAPE_HEADER_EXTRACTOR_CORE_ASSERT_SVH
`define OCTAL_ESCAPE_HEADER_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define OEHX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("oehx assertion failed");

// Next-cycle implication.
`define OEHX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("oehx assertion failed");

`endif

[rtl/oehx_pkg.sv]
package oehx_pkg;

  localparam int unsigned WINDOW_BYTES = 4096;
  localparam int unsigned HEADER_BYTES = 64;

  localparam int unsigned PosW = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned CntW = $clog2(HEADER_BYTES + 1);
  localparam int unsigned IdxW = 6;
  localparam int unsigned StW  = 3;

  // result queue
  localparam int unsigned MaxRes = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam int unsigned QIdxW  = $clog2(QDepth);

  localparam logic [63:0] MARKER_WORD = 64'h7072_696E_7466_2027;  // printf '
  localparam logic [7:0]  CH_QUOTE    = 8'h27;
  localparam logic [7:0]  CH_BSLASH   = 8'h5C;

  localparam logic [StW-1:0] ST_OK     = 3'd0;
  localparam logic [StW-1:0] ST_NOMARK = 3'd1;
  localparam logic [StW-1:0] ST_LONG   = 3'd2;
  localparam logic [StW-1:0] ST_SHORT  = 3'd3;
  localparam logic [StW-1:0] ST_MAGIC  = 3'd4;

  typedef struct packed {
    logic            kind;
    logic [7:0]      header_byte;
    logic [IdxW-1:0] byte_index;
    logic [StW-1:0]  status;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [1:0]              n;
    res_t [MaxRes-1:0]       res;
  } push_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h7F;
      2'd1:    b = 8'h45;
      2'd2:    b = 8'h4C;
      default: b = 8'h46;
    endcase
    return b;
  endfunction

  function automatic res_t mk_byte(input logic [7:0] b, input logic [CntW-1:0] idx);
    res_t r;
    r.kind        = 1'b0;
    r.header_byte = b;
    r.byte_index  = IdxW'(idx);
    r.status      = ST_OK;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_status(input logic [StW-1:0] st);
    res_t r;
    r.kind        = 1'b1;
    r.header_byte = '0;
    r.byte_index  = '0;
    r.status      = st;
    r.last        = 1'b1;
    return r;
  endfunction

endpackage

[rtl/oehx_parse.sv]
module oehx_parse import oehx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  input  logic       room_i,
  output push_t      push_o
);

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_DECODE = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_BSL  = 2'd1;
  localparam logic [1:0] ESC_ONE  = 2'd2;
  localparam logic [1:0] ESC_TWO  = 2'd3;

  // input word register
  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       first_q;
  logic       accept, adv;

  // parse state
  logic [55:0]     win_q, win_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]      ph_q, ph_d;
  logic [1:0]      esc_q, esc_d;
  logic [8:0]      ev_q, ev_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            mok_q, mok_d;

  logic [PosW-1:0]   qpos;
  logic              digit, match, emit, plain, plain_after;
  logic [7:0]        emit_val;
  logic [8:0]        new_ev;
  logic [1:0]        n_v;
  res_t [MaxRes-1:0] res_v;

  assign accept     = in_valid_i && !in_stall_o;
  assign adv        = vld_q && room_i;
  assign in_stall_o = vld_q && !room_i;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (adv) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q  <= data_byte_i;
      first_q <= first_byte_i;
    end
  end

  assign digit = (byte_q[7:3] == 5'b00110);

  always_comb begin
    win_d = win_q;
    pos_d = pos_q;
    ph_d  = ph_q;
    esc_d = esc_q;
    ev_d  = ev_q;
    cnt_d = cnt_q;
    mok_d = mok_q;
    if (first_q) begin
      win_d = '0;
      pos_d = '0;
      ph_d  = PH_SEARCH;
      esc_d = ESC_NONE;
      ev_d  = '0;
      cnt_d = '0;
      mok_d = 1'b1;
    end
    qpos = pos_d;
    if (pos_d < PosW'(WINDOW_BYTES)) begin
      pos_d = pos_d + 1'b1;
    end

    n_v         = '0;
    res_v       = '0;
    emit        = 1'b0;
    emit_val    = '0;
    plain       = 1'b0;
    plain_after = 1'b0;
    new_ev      = {ev_d[5:0], byte_q[2:0]};
    match       = ({win_d, byte_q} == MARKER_WORD);

    case (ph_d)
      PH_SEARCH: begin
        if (qpos >= PosW'(WINDOW_BYTES)) begin
          ph_d = PH_DONE;
        end else begin
          win_d = {win_d[47:0], byte_q};
          if (qpos >= PosW'(7) && match) begin
            ph_d = PH_DECODE;
          end else if (qpos >= PosW'(WINDOW_BYTES - 1)) begin
            res_v[n_v] = mk_status(ST_NOMARK);
            n_v        = n_v + 1'b1;
            ph_d       = PH_DONE;
          end
        end
      end
      PH_DECODE: begin
        if (esc_d == ESC_NONE) begin
          plain = 1'b1;
        end else if (digit && esc_d != ESC_TWO) begin
          ev_d  = new_ev;
          esc_d = esc_d + 1'b1;
        end else begin
          emit = 1'b1;
          if (digit) begin
            emit_val = new_ev[7:0];
            ev_d     = new_ev;
          end else if (esc_d == ESC_BSL) begin
            emit_val = CH_BSLASH;
          end else begin
            emit_val = ev_d[7:0];
          end
          esc_d       = ESC_NONE;
          plain_after = !digit;
        end
      end
      default: begin
      end
    endcase

    // byte that closes an escape
    if (emit) begin
      if (cnt_d >= CntW'(HEADER_BYTES)) begin
        res_v[n_v] = mk_status(ST_LONG);
        n_v        = n_v + 1'b1;
        ph_d       = PH_DONE;
        esc_d      = ESC_NONE;
      end else begin
        if (cnt_d < CntW'(4) && emit_val != magic_byte(cnt_d[1:0])) begin
          mok_d = 1'b0;
        end
        res_v[n_v] = mk_byte(emit_val, cnt_d);
        n_v        = n_v + 1'b1;
        cnt_d      = cnt_d + 1'b1;
        plain      = plain_after;
      end
    end

    // ordinary string byte
    if (plain) begin
      if (qpos > PosW'(WINDOW_BYTES - 4) || byte_q == CH_QUOTE) begin
        if (cnt_d != CntW'(HEADER_BYTES)) begin
          res_v[n_v] = mk_status(ST_SHORT);
        end else if (!mok_d) begin
          res_v[n_v] = mk_status(ST_MAGIC);
        end else begin
          res_v[n_v] = mk_status(ST_OK);
        end
        n_v   = n_v + 1'b1;
        ph_d  = PH_DONE;
        esc_d = ESC_NONE;
      end else if (byte_q == CH_BSLASH) begin
        esc_d = ESC_BSL;
        ev_d  = '0;
      end else if (cnt_d >= CntW'(HEADER_BYTES)) begin
        res_v[n_v] = mk_status(ST_LONG);
        n_v        = n_v + 1'b1;
        ph_d       = PH_DONE;
        esc_d      = ESC_NONE;
      end else begin
        if (cnt_d < CntW'(4) && byte_q != magic_byte(cnt_d[1:0])) begin
          mok_d = 1'b0;
        end
        res_v[n_v] = mk_byte(byte_q, cnt_d);
        n_v        = n_v + 1'b1;
        cnt_d      = cnt_d + 1'b1;
      end
    end

    // string bound reached with no escape open
    if (ph_d == PH_DECODE && esc_d == ESC_NONE && qpos >= PosW'(WINDOW_BYTES - 4)) begin
      if (cnt_d != CntW'(HEADER_BYTES)) begin
        res_v[n_v] = mk_status(ST_SHORT);
      end else if (!mok_d) begin
        res_v[n_v] = mk_status(ST_MAGIC);
      end else begin
        res_v[n_v] = mk_status(ST_OK);
      end
      n_v  = n_v + 1'b1;
      ph_d = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      pos_q <= '0;
      ph_q  <= PH_SEARCH;
      esc_q <= ESC_NONE;
      ev_q  <= '0;
      cnt_q <= '0;
      mok_q <= 1'b1;
    end else if (adv) begin
      win_q <= win_d;
      pos_q <= pos_d;
      ph_q  <= ph_d;
      esc_q <= esc_d;
      ev_q  <= ev_d;
      cnt_q <= cnt_d;
      mok_q <= mok_d;
    end
  end

  always_comb begin
    push_o.res = res_v;
    push_o.n   = adv ? n_v : 2'd0;
  end

endmodule

[rtl/oehx_resq.sv]
module oehx_resq import oehx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output res_t  res_o
);

  // shift queue, head always in slot 0
  res_t             slot_q [QDepth];
  res_t             slot_d [QDepth];
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [QCntW-1:0] base;
  logic [QCntW-1:0] wi;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign res_o       = slot_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q <= QCntW'(QDepth - MaxRes));

  always_comb begin
    slot_d = slot_q;
    base   = cnt_q;
    wi     = '0;
    if (pop) begin
      for (int i = 0; i < QDepth - 1; i++) begin
        slot_d[i] = slot_q[i + 1];
      end
      base = cnt_q - 1'b1;
    end
    for (int k = 0; k < MaxRes; k++) begin
      if (k < int'(push_i.n)) begin
        wi = base + QCntW'(k);
        slot_d[wi[QIdxW-1:0]] = push_i.res[k];
      end
    end
    cnt_d = base + QCntW'(push_i.n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

[rtl/octal_escape_header_extractor_core.sv]
// Ch  | Dir | Handshake               | Word
// ----+-----+-------------------------+------------------------------------------------------
// in  | in  | in_valid_i/in_stall_o   | data_byte_i, first_byte_i
// out | out | out_valid_o/out_stall_i | kind_o, header_byte_o, byte_index_o, status_o, last_o
//
// Takes one input word per cycle unless in_stall_o is high. Its results go from the input
// register into the result queue. A word may produce up to three result words; the result
// queue drains one word per cycle unless out_stall_i is high, so in_stall_o can rise.
// Reset (rst_ni low, asynchronous) empties both stages and puts the parser in marker search.
// in_stall_o rises only while the result queue lacks room for three words.
module octal_escape_header_extractor_core import oehx_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // byte stream
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            first_byte_i,
  // results
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            kind_o,
  output logic [7:0]      header_byte_o,
  output logic [IdxW-1:0] byte_index_o,
  output logic [StW-1:0]  status_o,
  output logic            last_o
);

  push_t push;   // results of the word in the input register
  logic  room;   // queue can absorb a worst-case word
  res_t  head;   // queue head

  // Input register plus the parser: marker search, escape decode, header count, magic check.
  oehx_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .room_i       (room),
    .push_o       (push)
  );

  // Result register: small queue, up to three pushes in, one word out per cycle unless stalled.
  oehx_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (head)
  );

  assign kind_o        = head.kind;
  assign header_byte_o = head.header_byte;
  assign byte_index_o  = head.byte_index;
  assign status_o      = head.status;
  assign last_o        = head.last;

endmodule

[rtl/oehx_chk.sv]
`include "octal_escape_header_extractor_core_assert.svh"

module oehx_chk import oehx_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic            kind_o,
  input logic [7:0]      header_byte_o,
  input logic [IdxW-1:0] byte_index_o,
  input logic [StW-1:0]  status_o,
  input logic            last_o
);

  // a stalled result word stays put
  `OEHX_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(kind_o) && $stable(header_byte_o) && $stable(byte_index_o) && $stable(status_o) && $stable(last_o))

  // byte words carry no status and no last flag
  `OEHX_ASSERT_IMP(a_byte_word, out_valid_o && !kind_o, !last_o && status_o == ST_OK)

  // status words are last, zero payload, legal code
  `OEHX_ASSERT_IMP(a_status_word, out_valid_o && kind_o, last_o && header_byte_o == 8'd0 && byte_index_o == '0 && (status_o == ST_OK || status_o == ST_NOMARK || status_o == ST_LONG || status_o == ST_SHORT || status_o == ST_MAGIC))

  // empty result queue always has room
  `OEHX_ASSERT_IMP(a_no_stall_empty, !out_valid_o, !in_stall_o)

endmodule

bind octal_escape_header_extractor_core oehx_chk u_chk (.*);

[dv/octal_escape_header_extractor_core_checker.sv]
module octal_escape_header_extractor_core_checker
  import oehx_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic [7:0]      data_byte_i,
  input  logic            first_byte_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  logic            kind_i,
  input  logic [7:0]      header_byte_i,
  input  logic [IdxW-1:0] byte_index_i,
  input  logic [StW-1:0]  status_i,
  input  logic            last_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {SEEK, DECODE, DONE} parse_e;

  localparam logic [1:0]  ESC_NONE    = 2'd0;
  localparam logic [1:0]  ESC_BSLASH  = 2'd1;
  localparam logic [1:0]  ESC_ONE     = 2'd2;
  localparam logic [1:0]  ESC_TWO     = 2'd3;
  localparam logic        WORD_BYTE   = 1'b0;
  localparam logic        WORD_STATUS = 1'b1;
  localparam logic [7:0]  DIGIT_ZERO  = 8'h30;
  localparam logic [7:0]  DIGIT_SEVEN = 8'h37;
  localparam logic [31:0] ELF_WORD    = 32'h7F45_4C46;

  logic [63:0] last_eight  = '0;
  int unsigned win_pos     = 0;
  parse_e      parse_phase = SEEK;
  logic [1:0]  esc_state   = ESC_NONE;
  logic [8:0]  esc_value   = '0;
  int unsigned hdr_count   = 0;
  bit          magic_match = 1'b1;
  res_t        due_results[$];
  int unsigned mismatches  = 0;

  function automatic void clear_parser();
    last_eight  = '0;
    win_pos     = 0;
    parse_phase = SEEK;
    esc_state   = ESC_NONE;
    esc_value   = '0;
    hdr_count   = 0;
    magic_match = 1'b1;
  endfunction

  function automatic void push_status(input logic [StW-1:0] st);
    res_t w;
    w.kind        = WORD_STATUS;
    w.header_byte = '0;
    w.byte_index  = '0;
    w.status      = st;
    w.last        = 1'b1;
    due_results.push_back(w);
    parse_phase = DONE;
    esc_state   = ESC_NONE;
  endfunction

  // closing quote or string bound
  function automatic void push_final();
    if (hdr_count != HEADER_BYTES) push_status(ST_SHORT);
    else if (!magic_match) push_status(ST_MAGIC);
    else push_status(ST_OK);
  endfunction

  // returns 0 when the header overflowed
  function automatic bit push_header_byte(input logic [7:0] b);
    res_t w;
    if (hdr_count >= HEADER_BYTES) begin
      push_status(ST_LONG);
      return 1'b0;
    end
    if (hdr_count < 4 && b != ELF_WORD[8*(3-hdr_count) +: 8]) magic_match = 1'b0;
    w.kind        = WORD_BYTE;
    w.header_byte = b;
    w.byte_index  = IdxW'(hdr_count);
    w.status      = ST_OK;
    w.last        = 1'b0;
    due_results.push_back(w);
    hdr_count++;
    return 1'b1;
  endfunction

  // string byte with no escape open
  function automatic void take_plain(input logic [7:0] c, input int unsigned q);
    if (q > WINDOW_BYTES - 4) push_final();
    else if (c == CH_QUOTE) push_final();
    else if (c == CH_BSLASH) begin
      esc_state = ESC_BSLASH;
      esc_value = '0;
    end else void'(push_header_byte(c));
  endfunction

  function automatic void parse_byte(input logic [7:0] c, input logic restart);
    int unsigned q;
    bit          digit;
    logic [7:0]  v;
    digit = (c >= DIGIT_ZERO && c <= DIGIT_SEVEN);
    if (restart) clear_parser();
    q = win_pos;
    if (win_pos < WINDOW_BYTES) win_pos++;
    case (parse_phase)
      SEEK: begin
        if (q >= WINDOW_BYTES) begin
          parse_phase = DONE;
          return;
        end
        last_eight = {last_eight[55:0], c};
        if (q >= 7 && last_eight == MARKER_WORD) parse_phase = DECODE;
        else begin
          if (q >= WINDOW_BYTES - 1) push_status(ST_NOMARK);
          return;
        end
      end
      DECODE: begin
        if (esc_state == ESC_NONE) take_plain(c, q);
        else if (digit && esc_state != ESC_TWO) begin
          esc_value = {esc_value[5:0], c[2:0]};
          esc_state = esc_state + 2'd1;
        end else if (digit) begin
          esc_value = {esc_value[5:0], c[2:0]};
          esc_state = ESC_NONE;
          void'(push_header_byte(esc_value[7:0]));
        end else begin
          // escape cut short: lone backslash or the digits so far
          v = (esc_state == ESC_BSLASH) ? CH_BSLASH : esc_value[7:0];
          esc_state = ESC_NONE;
          if (push_header_byte(v)) take_plain(c, q);
        end
      end
      default: return;
    endcase
    if (parse_phase == DECODE && esc_state == ESC_NONE && q >= WINDOW_BYTES - 4)
      push_final();
  endfunction

  function automatic void check_result();
    res_t want;
    if (due_results.size() == 0) begin
      $error("unexpected word: kind %0d byte %0h index %0d status %0d last %0d",
             kind_i, header_byte_i, byte_index_i, status_i, last_i);
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    if (kind_i !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, kind_i);
      mismatches++;
    end
    if (header_byte_i !== want.header_byte) begin
      $error("header_byte: expected %0h, got %0h", want.header_byte, header_byte_i);
      mismatches++;
    end
    if (byte_index_i !== want.byte_index) begin
      $error("byte_index: expected %0d, got %0d", want.byte_index, byte_index_i);
      mismatches++;
    end
    if (status_i !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status_i);
      mismatches++;
    end
    if (last_i !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, last_i);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      due_results.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) parse_byte(data_byte_i, first_byte_i);
      if (out_valid_i && !out_stall_i) check_result();
      fail_count_o <= mismatches;
      pending_o    <= due_results.size();
    end
  end

endmodule

[dv/octal_escape_header_extractor_core_test.sv]
module octal_escape_header_extractor_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import oehx_pkg::*;

  // run shape
  localparam int unsigned TOTAL_ITEMS   = 250;
  localparam int unsigned HOLD_CYCLES   = 80;    // long receiver hold-off
  localparam int unsigned IDLE_LIMIT    = 2000;  // cycles with no word moving
  localparam int unsigned SETTLE_CYCLES = 8;     // pipeline is two deep

  localparam logic [7:0]  DIGIT_ZERO = 8'h30;
  localparam logic [31:0] ELF_WORD   = 32'h7F45_4C46;

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            in_valid_i   = 1'b0;
  logic            in_stall_o;
  logic [7:0]      data_byte_i  = '0;
  logic            first_byte_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i  = 1'b0;
  logic            kind_o;
  logic [7:0]      header_byte_o;
  logic [IdxW-1:0] byte_index_o;
  logic [StW-1:0]  status_o;
  logic            last_o;

  int unsigned fail_total;
  int unsigned results_owed;

  // sender pacing
  bit          gaps_on    = 1'b1;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  // raised by the stimulus, cleared by the result sink once it starts holding
  logic        hold_req   = 1'b0;

  logic [7:0]  window_bytes[$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  octal_escape_header_extractor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .first_byte_i  (first_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .header_byte_o (header_byte_o),
    .byte_index_o  (byte_index_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  octal_escape_header_extractor_core_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .first_byte_i  (first_byte_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_i        (kind_o),
    .header_byte_i (header_byte_o),
    .byte_index_i  (byte_index_o),
    .status_i      (status_o),
    .last_i        (last_o),
    .fail_count_o  (fail_total),
    .pending_o     (results_owed)
  );

  // Offer one word and hold it until the block takes it. Words go out in
  // bursts; a gap may open before each new burst.
  task automatic send_word(input logic [7:0] b, input logic restart);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = 0;
      if (gaps_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    first_byte_i <= restart;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Stop sending until every predicted word has come out.
  // results_owed is registered, hence the first wait.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
  endtask

  task automatic send_window(input bit restart);
    int unsigned k;
    for (k = 0; k < window_bytes.size(); k++)
      send_word(window_bytes[k], restart && k == 0);
    window_bytes.delete();
  endtask

  task automatic push_marker();
    int unsigned k;
    for (k = 0; k < 8; k++) window_bytes.push_back(MARKER_WORD[8*(7-k) +: 8]);
  endtask

  task automatic push_filler(input int unsigned n);
    repeat (n) window_bytes.push_back(8'($urandom));
  endtask

  // One header byte as plain text, a full three-digit escape (sometimes with
  // the ninth bit set), or a short escape. A short escape that runs into a
  // digit gets merged; the checker follows whatever really goes out.
  task automatic push_encoded(input logic [7:0] b);
    int unsigned pick;
    logic [8:0]  v;
    pick = $urandom_range(0, 9);
    if (b != CH_QUOTE && b != CH_BSLASH && pick < 5) window_bytes.push_back(b);
    else if (pick == 9 && b < 8'd64) begin
      window_bytes.push_back(CH_BSLASH);
      if (b >= 8'd8) window_bytes.push_back(DIGIT_ZERO | {5'd0, b[5:3]});
      window_bytes.push_back(DIGIT_ZERO | {5'd0, b[2:0]});
    end else begin
      v = {1'b0, b};
      if ($urandom_range(0, 3) == 0) v[8] = 1'b1;
      window_bytes.push_back(CH_BSLASH);
      window_bytes.push_back(DIGIT_ZERO | {5'd0, v[8:6]});
      window_bytes.push_back(DIGIT_ZERO | {5'd0, v[5:3]});
      window_bytes.push_back(DIGIT_ZERO | {5'd0, v[2:0]});
    end
  endtask

  // Random window: junk, marker, encoded header, usually a closing quote,
  // then junk the block should skip. Some windows carry only a broken marker.
  task automatic build_random_window(input bit full_header);
    int unsigned mode;
    int unsigned hdr_len;
    int unsigned bad_slot;
    int unsigned k;
    logic [7:0]  b;
    push_filler($urandom_range(0, 6));
    mode = full_header ? 2 : $urandom_range(0, 9);
    if (mode < 2) begin
      // partial marker then noise: never leaves the search
      for (k = 0; k < $urandom_range(1, 7); k++)
        window_bytes.push_back(MARKER_WORD[8*(7-k) +: 8]);
      push_filler($urandom_range(2, 12));
      return;
    end
    push_marker();
    if (mode < 6) hdr_len = HEADER_BYTES;
    else if (mode < 8) hdr_len = $urandom_range(0, HEADER_BYTES - 1);
    else if (mode == 8) hdr_len = HEADER_BYTES + $urandom_range(1, 2);
    else hdr_len = $urandom_range(0, 10);
    // magic mostly intact; otherwise one bit flipped in one of its bytes
    bad_slot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 4;
    if (full_header) bad_slot = 4;
    for (k = 0; k < hdr_len; k++) begin
      b = 8'($urandom);
      if (k < 4) begin
        b = ELF_WORD[8*(3-k) +: 8];
        if (k == bad_slot) b = b ^ (8'd1 << $urandom_range(0, 7));
      end
      push_encoded(b);
      // rare backslash before a letter: literal backslash plus the letter
      if (!full_header && $urandom_range(0, 199) == 0) begin
        window_bytes.push_back(CH_BSLASH);
        window_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
      end
    end
    if (full_header || $urandom_range(0, 9) != 0) window_bytes.push_back(CH_QUOTE);
    push_filler($urandom_range(0, 3));
  endtask

  // Result sink: switches among four stall styles and serves one long
  // hold-off on request.
  initial begin : result_sink
    int unsigned cycle_no;
    int unsigned style;
    cycle_no = 0;
    style    = 0;
    forever begin
      @(posedge clk_i);
      cycle_no++;
      if (hold_req) begin
        hold_req    <= 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (cycle_no % 48 == 0) style = $urandom_range(0, 3);
      case (style)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 9) < 7);
        default: out_stall_i <= ((cycle_no % 5) < 2);
      endcase
    end
  end

  // Watchdog: too long with no word moving on either channel.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed window, no first_byte after reset. Decodes 7F E L F, \777
    // truncated to FF, backslash before a letter, backslash before backslash,
    // a one-digit escape ended by the closing quote (too short). Then two
    // words the block must skip.
    push_marker();
    window_bytes.push_back(CH_BSLASH);
    window_bytes.push_back(DIGIT_ZERO + 8'd1);
    window_bytes.push_back(DIGIT_ZERO + 8'd7);
    window_bytes.push_back(DIGIT_ZERO + 8'd7);
    window_bytes.push_back(8'h45);
    window_bytes.push_back(8'h4C);
    window_bytes.push_back(8'h46);
    window_bytes.push_back(CH_BSLASH);
    repeat (3) window_bytes.push_back(DIGIT_ZERO + 8'd7);
    window_bytes.push_back(CH_BSLASH);
    window_bytes.push_back(8'h71);
    window_bytes.push_back(CH_BSLASH);
    window_bytes.push_back(CH_BSLASH);
    window_bytes.push_back(DIGIT_ZERO);
    window_bytes.push_back(CH_QUOTE);
    window_bytes.push_back(8'h00);
    window_bytes.push_back(8'hFF);
    send_window(1'b0);

    // Full header while the sink holds off: the result queue fills and the
    // input must stall. Then pause until everything has drained.
    gaps_on = 1'b0;
    hold_req <= 1'b1;
    build_random_window(1'b1);
    send_window(1'b1);
    wait_drain();

    // at least one random window, then until the item budget is spent
    do begin
      gaps_on = ($urandom_range(0, 2) != 0);
      build_random_window(1'b0);
      send_window(1'b1);
      if ($urandom_range(0, 3) == 0) wait_drain();
    end while (items_sent < TOTAL_ITEMS);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
